[src/ipra_pkg.sv]
// ----------------------------------------------------------------------------
// ipra_pkg
// Shared types, request codes and defaults for the I/O port range allocator.
// ----------------------------------------------------------------------------
package ipra_pkg;

    localparam int DefFreeEntries = 16;
    localparam int DefUsedEntries = 16;
    localparam int DefLowestPort  = 0;
    localparam int DefHighestPort = 65535;

    localparam logic [1:0] REQ_RESERVE = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_CHECK   = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // capture request
        logic scan;      // step through one table entry
        logic fin_rsv;   // reserve: remove entry and insert fragments
        logic fin_rel;   // release: apply merge or insert
        logic done;      // publish result
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic scan_last; // scan reached the end
        logic busy;      // a shift or insert is still running
    } t_sts;

endpackage

[src/ipra_ctrl.sv]
// ----------------------------------------------------------------------------
// ipra_ctrl
// Request sequencer: load, scan the tables, update them, deliver the result.
// ----------------------------------------------------------------------------
module ipra_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [1:0]      i_req_type,
    input  ipra_pkg::t_sts  i_sts,
    output ipra_pkg::t_cmd  o_cmd,
    output logic            o_valid,
    input  logic            i_out_ready
);
    import ipra_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] r_state, n_state;
    logic [1:0] r_type;
    logic       r_valid;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && !r_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) n_state = S_UPD;
            end
            S_UPD: begin
                if (r_type == REQ_RESERVE) o_cmd.fin_rsv = 1'b1;
                else if (r_type == REQ_RELEASE) o_cmd.fin_rel = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (!i_sts.busy) begin
                    o_cmd.done = 1'b1;
                    n_state    = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_valid) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.done) r_valid <= 1'b1;
            else if (r_valid && i_out_ready) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd.load) r_type <= i_req_type;
    end

endmodule

[src/ipra_dp.sv]
// ----------------------------------------------------------------------------
// ipra_dp
// Free and reserved range tables with a one-entry-per-cycle scan unit and a
// shift engine that removes and inserts free entries one step a cycle.
// ----------------------------------------------------------------------------
module ipra_dp #(
    parameter int FreeEntries = ipra_pkg::DefFreeEntries,
    parameter int UsedEntries = ipra_pkg::DefUsedEntries,
    parameter int LowestPort  = ipra_pkg::DefLowestPort,
    parameter int HighestPort = ipra_pkg::DefHighestPort
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ipra_pkg::t_cmd  i_cmd,
    output ipra_pkg::t_sts  o_sts,
    input  logic [1:0]      i_req_type,
    input  logic            i_resource_is_io,
    input  logic [15:0]     i_start_port,
    input  logic [15:0]     i_end_port,
    output logic            o_ok,
    output logic [15:0]     o_granted_start,
    output logic [15:0]     o_granted_end
);
    import ipra_pkg::*;

    localparam int FW = (FreeEntries > 1) ? $clog2(FreeEntries) : 1;
    localparam int UW = (UsedEntries > 1) ? $clog2(UsedEntries) : 1;
    localparam int CW = FW + 1;
    localparam int SW = ((FreeEntries > UsedEntries) ? FreeEntries : UsedEntries);
    localparam int XW = $clog2(SW + 1);
    localparam logic [15:0] LoP = 16'(LowestPort);
    localparam logic [15:0] HiP = 16'(HighestPort);

    // shift engine operations
    localparam logic [2:0] OP_IDLE   = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_INS_A  = 3'd2;
    localparam logic [2:0] OP_INS_B  = 3'd3;

    // free table: valid entries form a prefix of length r_fcnt
    logic [15:0] r_fs [FreeEntries];
    logic [15:0] r_fe [FreeEntries];
    logic [CW-1:0] r_fcnt;
    logic [15:0] r_us [UsedEntries];
    logic [15:0] r_ue [UsedEntries];
    logic [UsedEntries-1:0] r_uv;

    // request
    logic [1:0]  r_type;
    logic        r_io;
    logic [15:0] r_s, r_e;
    logic [XW-1:0] r_i;

    // scan results
    logic          r_found, r_pot, r_umatch, r_slot_ok, r_p_done;
    logic [FW-1:0] r_fidx, r_pidx;
    logic [UW-1:0] r_uidx, r_slot;
    logic [CW-1:0] r_p;      // first entry with start >= end

    // shift engine: ops queued as remove/insert
    logic          r_busy;
    logic [2:0]    r_ops;    // idle, remove, insert A, insert B
    logic [CW-1:0] r_k;
    logic [CW-1:0] r_tgt;
    logic          r_insa, r_insb;
    logic [15:0]   r_as, r_ae, r_bs, r_be;

    logic        r_ok;
    logic [15:0] r_gs, r_ge;

    logic          valid_req;
    logic [15:0]   cur_s, cur_e;
    logic [16:0]   size;
    logic [FW-1:0] iw;
    logic [UW-1:0] iu;

    assign valid_req = r_io && (r_e >= r_s);
    assign size      = {1'b0, r_e} - {1'b0, r_s} + 17'd1;
    assign iw        = r_i[FW-1:0];
    assign iu        = r_i[UW-1:0];
    assign cur_s     = r_fs[iw];
    assign cur_e     = r_fe[iw];

    assign o_sts.scan_last = (r_i >= XW'(SW - 1));
    assign o_sts.busy      = r_busy;
    assign o_ok            = r_ok;
    assign o_granted_start = r_gs;
    assign o_granted_end   = r_ge;

    // position search for an insert of range ending at value
    logic [CW-1:0] ins_pos;
    logic [15:0]   ins_key;
    always_comb begin
        ins_key = (r_ops == OP_INS_A) ? r_ae : r_be;
        ins_pos = r_fcnt;
        for (int j = FreeEntries - 1; j >= 0; j--) begin
            if (CW'(j) < r_fcnt && r_fs[j] >= ins_key) ins_pos = CW'(j);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcnt <= CW'(1);
            r_fs[0] <= LoP;
            r_fe[0] <= HiP;
            r_uv   <= '0;
            r_busy <= 1'b0;
            r_ops  <= OP_IDLE;
        end else begin
            // capture and scan reset
            if (i_cmd.load) begin
                r_type    <= i_req_type;
                r_io      <= i_resource_is_io;
                r_s       <= i_start_port;
                r_e       <= i_end_port;
                r_i       <= '0;
                r_found   <= 1'b0;
                r_pot     <= 1'b0;
                r_umatch  <= 1'b0;
                r_slot_ok <= 1'b0;
                r_p_done  <= 1'b0;
                r_p       <= '0;
                r_fidx    <= '0;
                r_pidx    <= '0;
                r_uidx    <= '0;
                r_slot    <= '0;
            end
            // one entry of each table per cycle
            if (i_cmd.scan) begin
                r_i <= r_i + XW'(1);
                if (r_i < XW'(FreeEntries) && CW'(r_i) < r_fcnt) begin
                    if (!r_p_done) begin
                        if (cur_s < r_e) r_p <= CW'(r_i) + CW'(1);
                        else r_p_done <= 1'b1;
                    end
                    if (!r_found) begin
                        if (cur_s <= r_s && cur_e >= r_e) begin
                            r_found <= 1'b1;
                            r_fidx  <= iw;
                        end else if (cur_e >= cur_s &&
                                     {1'b0, cur_e - cur_s} >= size) begin
                            r_pot  <= 1'b1;
                            r_pidx <= iw;
                        end
                    end
                end
                if (r_i < XW'(UsedEntries)) begin
                    if (!r_uv[iu] && !r_slot_ok) begin
                        r_slot_ok <= 1'b1;
                        r_slot    <= iu;
                    end
                    if (r_uv[iu] && !r_umatch && r_us[iu] == r_s && r_ue[iu] == r_e) begin
                        r_umatch <= 1'b1;
                        r_uidx   <= iu;
                    end
                end
            end
            // default result echoes request
            if (i_cmd.scan && o_sts.scan_last) begin
                r_ok <= 1'b0;
                r_gs <= r_s;
                r_ge <= r_e;
            end
            // check result once the whole free table is scanned
            if (i_cmd.done && r_type == REQ_CHECK && valid_req)
                r_ok <= r_found;
            // reserve update
            if (i_cmd.fin_rsv && valid_req && r_slot_ok &&
                ({1'b0, r_e - r_s} < 17'(HighestPort)) && (r_found || r_pot)) begin
                r_ok    <= 1'b1;
                r_busy  <= 1'b1;
                r_ops   <= OP_REMOVE;
                r_uv[r_slot] <= 1'b1;
                if (r_found) begin
                    r_k    <= CW'(r_fidx);
                    r_as   <= r_fs[r_fidx];
                    r_ae   <= r_s - 16'd1;
                    r_insa <= r_fs[r_fidx] < r_s;
                    r_bs   <= r_e + 16'd1;
                    r_be   <= r_fe[r_fidx];
                    r_insb <= r_fe[r_fidx] > r_e;
                    r_us[r_slot] <= r_s;
                    r_ue[r_slot] <= r_e;
                end else begin
                    r_k    <= CW'(r_pidx);
                    r_insa <= 1'b0;
                    r_bs   <= r_fs[r_pidx] + size[15:0];
                    r_be   <= r_fe[r_pidx];
                    r_insb <= 1'b1;
                    r_gs   <= r_fs[r_pidx];
                    r_ge   <= r_fs[r_pidx] + size[15:0] - 16'd1;
                    r_us[r_slot] <= r_fs[r_pidx];
                    r_ue[r_slot] <= r_fs[r_pidx] + size[15:0] - 16'd1;
                end
            end
            // release update
            if (i_cmd.fin_rel && valid_req && r_umatch) begin
                logic jl, jr;
                jl = (r_p != '0) && ({1'b0, r_fe[FW'(r_p - CW'(1))]} + 17'd1 == {1'b0, r_s});
                jr = (r_p < r_fcnt) && ({1'b0, r_e} + 17'd1 == {1'b0, r_fs[FW'(r_p)]});
                if (jl && jr) begin
                    r_fe[FW'(r_p - CW'(1))] <= r_fe[FW'(r_p)];
                    r_k    <= r_p;
                    r_ops  <= OP_REMOVE;
                    r_busy <= 1'b1;
                    r_insa <= 1'b0;
                    r_insb <= 1'b0;
                    r_ok   <= 1'b1;
                    r_uv[r_uidx] <= 1'b0;
                end else if (jl) begin
                    r_fe[FW'(r_p - CW'(1))] <= r_e;
                    r_ok <= 1'b1;
                    r_uv[r_uidx] <= 1'b0;
                end else if (jr) begin
                    r_fs[FW'(r_p)] <= r_s;
                    r_ok <= 1'b1;
                    r_uv[r_uidx] <= 1'b0;
                end else if (r_fcnt < CW'(FreeEntries)) begin
                    r_as   <= r_s;
                    r_ae   <= r_e;
                    r_insa <= 1'b1;
                    r_insb <= 1'b0;
                    r_ops  <= OP_INS_A;
                    r_tgt  <= r_fcnt;
                    r_k    <= '0;
                    r_busy <= 1'b1;
                    r_ok   <= 1'b1;
                    r_uv[r_uidx] <= 1'b0;
                end
            end
            // shift engine, one entry per cycle
            if (r_busy) begin
                unique case (r_ops)
                    OP_REMOVE: begin
                        if (r_k + CW'(1) < r_fcnt) begin
                            r_fs[FW'(r_k)] <= r_fs[FW'(r_k + CW'(1))];
                            r_fe[FW'(r_k)] <= r_fe[FW'(r_k + CW'(1))];
                            r_k <= r_k + CW'(1);
                        end else begin
                            r_fcnt <= r_fcnt - CW'(1);
                            r_k    <= '0;
                            if (r_insa) begin
                                r_ops <= OP_INS_A;
                                r_tgt <= r_fcnt - CW'(1);
                            end else if (r_insb) begin
                                r_ops <= OP_INS_B;
                                r_tgt <= r_fcnt - CW'(1);
                            end else begin
                                r_ops  <= OP_IDLE;
                                r_busy <= 1'b0;
                            end
                        end
                    end
                    OP_INS_A, OP_INS_B: begin
                        if (r_fcnt >= CW'(FreeEntries)) begin
                            // table full: fragment dropped
                            if (r_ops == OP_INS_A && r_insb) begin
                                r_ops <= OP_INS_B;
                            end else begin
                                r_ops <= OP_IDLE;
                                r_busy <= 1'b0;
                            end
                        end else if (r_tgt > ins_pos) begin
                            r_fs[FW'(r_tgt)] <= r_fs[FW'(r_tgt - CW'(1))];
                            r_fe[FW'(r_tgt)] <= r_fe[FW'(r_tgt - CW'(1))];
                            r_tgt <= r_tgt - CW'(1);
                        end else begin
                            r_fs[FW'(r_tgt)] <= (r_ops == OP_INS_A) ? r_as : r_bs;
                            r_fe[FW'(r_tgt)] <= (r_ops == OP_INS_A) ? r_ae : r_be;
                            r_fcnt <= r_fcnt + CW'(1);
                            if (r_ops == OP_INS_A && r_insb) begin
                                r_ops <= OP_INS_B;
                                r_tgt <= r_fcnt + CW'(1);
                            end else begin
                                r_ops  <= OP_IDLE;
                                r_busy <= 1'b0;
                            end
                        end
                    end
                    default: begin
                        r_ops  <= OP_IDLE;
                        r_busy <= 1'b0;
                    end
                endcase
            end
        end
    end

endmodule

[src/io_port_range_allocator.sv]
// ----------------------------------------------------------------------------
// io_port_range_allocator
// Top level: reserve, release and check of I/O port ranges.
// ----------------------------------------------------------------------------
// One request at a time. A request scans both tables one entry per cycle,
// covering as many entries as the larger of FREE_ENTRIES and USED_ENTRIES,
// then a shift engine moves free-table entries one per cycle to remove and
// insert ranges. Both the scan and the shift datapath handle a single entry
// per step.
// A result stays on the output until taken; the next item is accepted after.
module io_port_range_allocator #(
    parameter int FREE_ENTRIES = ipra_pkg::DefFreeEntries,
    parameter int USED_ENTRIES = ipra_pkg::DefUsedEntries,
    parameter int LOWEST_PORT  = ipra_pkg::DefLowestPort,
    parameter int HIGHEST_PORT = ipra_pkg::DefHighestPort
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic        i_resource_is_io,
    input  logic [15:0] i_start_port,
    input  logic [15:0] i_end_port,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_ok,
    output logic [15:0] o_granted_start,
    output logic [15:0] o_granted_end
);
    import ipra_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ipra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_valid     (o_valid),
        .i_out_ready (i_ready)
    );

    ipra_dp #(
        .FreeEntries (FREE_ENTRIES),
        .UsedEntries (USED_ENTRIES),
        .LowestPort  (LOWEST_PORT),
        .HighestPort (HIGHEST_PORT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_req_type       (i_req_type),
        .i_resource_is_io (i_resource_is_io),
        .i_start_port     (i_start_port),
        .i_end_port       (i_end_port),
        .o_ok             (o_ok),
        .o_granted_start  (o_granted_start),
        .o_granted_end    (o_granted_end)
    );

endmodule
